[sv/periodic_timer_bank_defines.svh]
// ----------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that holds at every edge
`define PTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("periodic_timer_bank check failed");
// Condition that must be followed by an outcome in the next cycle
`define PTB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("periodic_timer_bank check failed");
`else
`define PTB_ASSERT(lbl, prop)
`define PTB_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[sv/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Codes, field widths and constants of the timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // Bank size default and fixed limits
  localparam int NUM_SLOTS_DEF = 16;
  localparam int NUM_IDS       = 16;
  localparam int RES_CAP       = 16;
  localparam int RPT_W         = $clog2(RES_CAP + 1);
  localparam int PER_W         = 23;
  localparam logic [7:0] MAX_ARG_BYTES = 8'd32;

  // ms / 1000 == (ms >> 3) / 125 == ((ms >> 3) * TICK_RECIP) >> TICK_SHIFT
  localparam int TICK_SHIFT = 36;
  localparam logic [29:0] TICK_RECIP = 30'd549755814;

  // Operations
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_KILL = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_KILL   = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_REQ  = 2'd1;
  localparam logic [1:0] ST_ARG_LONG = 2'd2;
  localparam logic [1:0] ST_NO_SLOT  = 2'd3;

endpackage

[sv/periodic_timer_bank.sv]
// ----------------------------------------------------------------------------
// Periodic timer bank
// Timer slots with a logical id map; period and count live in one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                         | tuser     | tlast
//  in_     | in  | timer_id, interval_ms, has_handler, has_arg,  | operation | -
//          |     | arg_len                                       |           |
//  out_    | out | status, slot                                  | kind      | last
//
//  Tick: slot RAM read-modify-write, one slot per cycle unless a stalled result
//  holds the scan, then the final expiry beat is handed out.
//  Set: a bad request is answered without a scan; else the scan steps once per
//  enabled slot below the free one, or over all slots when no slot is free.
//  Kill: releases the mapping and replies.
//  Reset is synchronous; the slot RAM needs no clearing pass (enable bits gate it).
//  A stalled result channel holds the tick scan only when a new expiry must be sent.
`include "periodic_timer_bank_defines.svh"

module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] timer_id, [35:4] interval_ms, [36] has_handler, [37] has_arg,
  // [45:38] arg_len, [47:46] zero
  input  logic [47:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [5:2] slot, [7:6] zero
  output logic [7:0]  out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int WORD_W = 2 * PER_W;
  localparam int PROD_W = 59;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_CHK    = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_KILL   = 8'b0001_0000,
    S_RESP   = 8'b0010_0000,
    S_TICK   = 8'b0100_0000,
    S_TFLUSH = 8'b1000_0000
  } state_t;

  // Control state
  state_t                state_r, state_nxt;
  logic [NUM_SLOTS-1:0]  en_r, en_nxt;
  logic [NUM_IDS-1:0]    map_valid_r, map_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  hold_valid_r, hold_valid_nxt;
  logic                  pend_r, pend_nxt;

  // Payload
  logic [SLOT_W-1:0]     map_slot_r [NUM_IDS];
  logic [SLOT_W-1:0]     map_slot_nxt [NUM_IDS];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [RPT_W-1:0]      n_r, n_nxt;
  logic [3:0]            hold_slot_r, hold_slot_nxt;
  logic [3:0]            id_r, id_nxt;
  logic [31:0]           ms_r, ms_nxt;
  logic                  handler_r, handler_nxt;
  logic                  arg_bad_r, arg_bad_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [1:0]            resp_kind_r, resp_kind_nxt;
  logic [1:0]            resp_status_r, resp_status_nxt;
  logic [3:0]            resp_slot_r, resp_slot_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [3:0]            out_slot_r, out_slot_nxt;
  logic                  out_last_r, out_last_nxt;

  // Slot RAM: {period, count} per slot
  logic [WORD_W-1:0]     mem [NUM_SLOTS];
  logic [WORD_W-1:0]     mem_q_r;
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0]     mem_wdata;

  // Datapath helpers
  logic                  out_free;
  logic [PER_W-1:0]      ticks;
  logic [PER_W-1:0]      q_period, q_count, cnt_inc;
  logic                  p_en, hit, want_report, stall;
  logic [SLOT_W-1:0]     scan_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign out_free = !out_valid_r || out_tready;
  assign ticks    = prod_r[TICK_SHIFT +: PER_W];
  assign scan_idx = cnt_r[SLOT_W-1:0];

  // Tick pipeline: slot at pend_idx_r has its RAM word in mem_q_r
  assign q_period    = mem_q_r[WORD_W-1:PER_W];
  assign q_count     = mem_q_r[PER_W-1:0];
  assign cnt_inc     = q_count + PER_W'(1);
  assign p_en        = pend_r && en_r[pend_idx_r];
  assign hit         = p_en && (cnt_inc == q_period);
  assign want_report = hit && (n_r < RPT_W'(RES_CAP));
  assign stall       = want_report && hold_valid_r && !out_free;

  // Next-state logic
  always_comb begin
    state_nxt       = state_r;
    en_nxt          = en_r;
    map_valid_nxt   = map_valid_r;
    map_slot_nxt    = map_slot_r;
    hold_valid_nxt  = hold_valid_r;
    pend_nxt        = pend_r;
    cnt_nxt         = cnt_r;
    pend_idx_nxt    = pend_idx_r;
    n_nxt           = n_r;
    hold_slot_nxt   = hold_slot_r;
    id_nxt          = id_r;
    ms_nxt          = ms_r;
    handler_nxt     = handler_r;
    arg_bad_nxt     = arg_bad_r;
    prod_nxt        = prod_r;
    resp_kind_nxt   = resp_kind_r;
    resp_status_nxt = resp_status_r;
    resp_slot_nxt   = resp_slot_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = pend_idx_r;
    mem_wdata       = {q_period, cnt_inc};
    mem_raddr       = cnt_r[SLOT_W-1:0];

    unique case (state_r)
      // Take a beat and dispatch on the operation
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt      = in_tdata[3:0];
          ms_nxt      = in_tdata[35:4];
          handler_nxt = in_tdata[36];
          arg_bad_nxt = in_tdata[37] && (in_tdata[45:38] > MAX_ARG_BYTES);
          case (in_tuser)
            OP_TICK: begin
              cnt_nxt        = '0;
              n_nxt          = '0;
              pend_nxt       = 1'b0;
              hold_valid_nxt = 1'b0;
              state_nxt      = S_TICK;
            end
            OP_SET:  state_nxt = S_DIV;
            OP_KILL: state_nxt = S_KILL;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Multiply by the reciprocal of 1000 and release the old mapping
      S_DIV: begin
        prod_nxt = PROD_W'(ms_r[31:3] * TICK_RECIP);
        if (map_valid_r[id_r]) begin
          en_nxt[map_slot_r[id_r]] = 1'b0;
          map_valid_nxt[id_r]      = 1'b0;
        end
        state_nxt = S_CHK;
      end

      // Reject a missing handler or a zero period, else start the scan
      S_CHK: begin
        resp_kind_nxt = KIND_SET;
        resp_slot_nxt = 4'd0;
        if (!handler_r || (ticks == '0)) begin
          resp_status_nxt = ST_BAD_REQ;
          state_nxt       = S_RESP;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      // Walk the enable bits for the lowest free slot
      S_SCAN: begin
        if (cnt_r == CNT_W'(NUM_SLOTS)) begin
          resp_status_nxt = ST_NO_SLOT;
          state_nxt       = S_RESP;
        end else if (!en_r[scan_idx]) begin
          if (arg_bad_r) begin
            resp_status_nxt = ST_ARG_LONG;
          end else begin
            en_nxt[scan_idx]    = 1'b1;
            mem_we              = 1'b1;
            mem_waddr           = scan_idx;
            mem_wdata           = {ticks, PER_W'(0)};
            map_valid_nxt[id_r] = 1'b1;
            map_slot_nxt[id_r]  = scan_idx;
            resp_status_nxt     = ST_OK;
            resp_slot_nxt       = 4'(scan_idx);
          end
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Release the mapped slot
      S_KILL: begin
        if (map_valid_r[id_r]) begin
          en_nxt[map_slot_r[id_r]] = 1'b0;
          map_valid_nxt[id_r]      = 1'b0;
        end
        resp_kind_nxt   = KIND_KILL;
        resp_status_nxt = ST_OK;
        resp_slot_nxt   = 4'd0;
        state_nxt       = S_RESP;
      end

      // Hand the single reply beat to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = resp_kind_r;
          out_status_nxt = resp_status_r;
          out_slot_nxt   = resp_slot_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // Read slot cnt_r while updating slot pend_idx_r; keep one expiry
      // in hold so the final beat can carry last
      S_TICK: begin
        if (!stall) begin
          if (p_en) begin
            mem_we    = 1'b1;
            mem_wdata = {q_period, hit ? PER_W'(0) : cnt_inc};
          end
          if (want_report) begin
            if (hold_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_EXPIRY;
              out_status_nxt = ST_OK;
              out_slot_nxt   = hold_slot_r;
              out_last_nxt   = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_slot_nxt  = 4'(pend_idx_r);
            n_nxt          = n_r + RPT_W'(1);
          end
          if (cnt_r < CNT_W'(NUM_SLOTS)) begin
            mem_re       = 1'b1;
            pend_nxt     = 1'b1;
            pend_idx_nxt = cnt_r[SLOT_W-1:0];
            cnt_nxt      = cnt_r + CNT_W'(1);
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = S_TFLUSH;
          end
        end
      end

      // Send the held expiry, if any, as the final beat
      S_TFLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_EXPIRY;
          out_status_nxt = ST_OK;
          out_slot_nxt   = hold_slot_r;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      en_r         <= '0;
      map_valid_r  <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      en_r         <= en_nxt;
      map_valid_r  <= map_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    map_slot_r    <= map_slot_nxt;
    cnt_r         <= cnt_nxt;
    pend_idx_r    <= pend_idx_nxt;
    n_r           <= n_nxt;
    hold_slot_r   <= hold_slot_nxt;
    id_r          <= id_nxt;
    ms_r          <= ms_nxt;
    handler_r     <= handler_nxt;
    arg_bad_r     <= arg_bad_nxt;
    prod_r        <= prod_nxt;
    resp_kind_r   <= resp_kind_nxt;
    resp_status_r <= resp_status_nxt;
    resp_slot_r   <= resp_slot_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Slot RAM; tick reads slot i+1 while writing slot i, so no entry overlaps
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Checks
  `PTB_ASSERT(a_idle_clean, in_tready |-> (!hold_valid_r && !pend_r))
  `PTB_ASSERT(a_pend_in_tick, pend_r |-> (state_r == S_TICK))
  `PTB_ASSERT(a_report_cap, (state_r == S_TICK) |-> (n_r <= RPT_W'(RES_CAP)))
  `PTB_ASSERT_NEXT(a_flush_ends, (state_r == S_TFLUSH) && !hold_valid_r, state_r == S_IDLE)

endmodule
